[sv/trfd_pkg.sv]
// trfd_pkg: shared types and constants for the touch report frame decoder
// used by trfd_front, trfd_queue, trfd_back and the top level; no dependencies
`timescale 1ns / 1ps

package trfd_pkg;

	// event codes on the result channel
	typedef enum logic [1:0] {
		EV_TOUCH   = 2'd0,
		EV_RELEASE = 2'd1,
		EV_CLEAR   = 2'd2
	} ev_kind_t;

	// status byte fields
	localparam logic [7:0] READY_MASK = 8'h80;
	localparam logic [7:0] COUNT_MASK = 8'h0f;

	// byte positions inside one point record
	localparam logic [2:0] POS_ID   = 3'd0;
	localparam logic [2:0] POS_X_LO = 3'd1;
	localparam logic [2:0] POS_X_HI = 3'd2;
	localparam logic [2:0] POS_Y_LO = 3'd3;
	localparam logic [2:0] POS_Y_HI = 3'd4;
	localparam logic [2:0] POS_W_LO = 3'd5;
	localparam logic [2:0] POS_W_HI = 3'd6;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// one queued job: a first event, optionally followed by a clear-status event
	typedef struct packed {
		logic        two;
		ev_kind_t    kind;
		logic [3:0]  id;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] w;
	} job_t;

	// a bare clear-status event
	localparam job_t CLEAR_JOB = '{two: 1'b0, kind: EV_CLEAR, id: 4'd0,
		x: 16'd0, y: 16'd0, w: 16'd0};

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

[sv/trfd_front.sv]
// trfd_front: accepts report bytes, tracks frame state, assembles point records
// and pushes event jobs; depends on trfd_pkg
`timescale 1ns / 1ps

module trfd_front #(
	parameter int MAX_POINTS = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             touch_disable,
	input  logic             raw_mode,
	input  logic             accept,
	input  logic             frame_start,
	input  logic [7:0]       data_byte,
	output logic             push,
	output trfd_pkg::job_t   push_job
);
	import trfd_pkg::*;

	logic        in_frame_q;
	logic [3:0]  points_left_q;
	logic [2:0]  byte_in_point_q;
	logic [3:0]  prev_count_q;
	logic [3:0]  rec_id_q;
	logic [15:0] rec_x_q;
	logic [15:0] rec_y_q;
	logic [7:0]  rec_w_q;

	logic [3:0]  count;
	logic        rejected;
	logic        opens;
	logic [3:0]  pl_dec;
	logic        last_point;

	assign count      = data_byte[3:0] & COUNT_MASK[3:0];
	assign rejected   = ((data_byte & READY_MASK) == 8'h00) || (count > 4'(MAX_POINTS));
	assign opens      = (data_byte != 8'h00) && !rejected && (count != 4'd0);
	assign pl_dec     = points_left_q - 4'd1;
	assign last_point = (pl_dec == 4'd0);

	// classify the byte into at most one job
	always_comb begin
		push          = 1'b0;
		push_job      = '0;
		push_job.kind = EV_CLEAR;
		push_job.id   = rec_id_q;
		push_job.x    = rec_x_q;
		push_job.y    = rec_y_q;
		push_job.w    = {data_byte, rec_w_q};
		if (accept) begin
			if (frame_start) begin
				push_job = '0;
				push_job.kind = EV_CLEAR;
				if (data_byte == 8'h00) begin
					push = 1'b0;
				end else if (rejected) begin
					push = !raw_mode;
				end else if (count == 4'd0) begin
					if (prev_count_q != 4'd0) begin
						push          = 1'b1;
						push_job.kind = EV_RELEASE;
						push_job.two  = !raw_mode;
					end else begin
						push = !raw_mode;
					end
				end
			end else if (in_frame_q && byte_in_point_q == POS_W_HI) begin
				if (!touch_disable) begin
					push          = 1'b1;
					push_job.kind = EV_TOUCH;
					push_job.two  = last_point && !raw_mode;
				end else begin
					push          = last_point && !raw_mode;
					push_job      = '0;
					push_job.kind = EV_CLEAR;
				end
			end
		end
	end

	// frame state and record assembly
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q      <= 1'b0;
			points_left_q   <= 4'd0;
			byte_in_point_q <= 3'd0;
			prev_count_q    <= 4'd0;
			rec_id_q        <= 4'd0;
			rec_x_q         <= 16'd0;
			rec_y_q         <= 16'd0;
			rec_w_q         <= 8'd0;
		end else if (accept) begin
			if (frame_start) begin
				in_frame_q      <= opens;
				points_left_q   <= opens ? count : 4'd0;
				byte_in_point_q <= 3'd0;
				if (data_byte != 8'h00 && !rejected) begin
					prev_count_q <= count;
				end
			end else if (in_frame_q) begin
				// the last point closes the frame
				if (byte_in_point_q == POS_W_HI && last_point) begin
					in_frame_q      <= 1'b0;
					byte_in_point_q <= 3'd0;
				end else begin
					byte_in_point_q <= byte_in_point_q + 3'd1;
				end
				unique case (byte_in_point_q)
					POS_ID: begin
						rec_id_q <= data_byte[3:0];
						rec_x_q  <= 16'd0;
						rec_y_q  <= 16'd0;
						rec_w_q  <= 8'd0;
					end
					POS_X_LO: rec_x_q[7:0]  <= data_byte;
					POS_X_HI: rec_x_q[15:8] <= data_byte;
					POS_Y_LO: rec_y_q[7:0]  <= data_byte;
					POS_Y_HI: rec_y_q[15:8] <= data_byte;
					POS_W_LO: rec_w_q       <= data_byte;
					POS_W_HI: points_left_q <= pl_dec;
					default: ;
				endcase
			end
		end
	end

endmodule

[sv/trfd_queue.sv]
// trfd_queue: short job queue between the front and the back
// depends on trfd_pkg
`timescale 1ns / 1ps

module trfd_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  trfd_pkg::job_t       push_job,
	input  logic                 pop,
	output trfd_pkg::job_t       head_job,
	output trfd_pkg::q_status_t  status
);
	import trfd_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign status.full  = (count_q == QCNT_W'(QDEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head_job     = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

[sv/trfd_back.sv]
// trfd_back: pops jobs and drives the result channel through an output register
// depends on trfd_pkg
`timescale 1ns / 1ps

module trfd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  trfd_pkg::job_t       head_job,
	input  trfd_pkg::q_status_t  q_status,
	output logic                 pop,
	input  logic                 out_stall,
	output logic                 out_valid,
	output trfd_pkg::job_t       out_job,
	output logic                 out_last
);
	import trfd_pkg::*;

	logic valid_q;
	logic second_q;
	logic last_q;
	job_t job_q;
	logic load;

	assign load      = !valid_q || !out_stall;
	assign pop       = load && !second_q && !q_status.empty;
	assign out_valid = valid_q;
	assign out_job   = job_q;
	assign out_last  = last_q;

	// control: output valid and pending clear-status word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else if (load) begin
			if (second_q) begin
				valid_q  <= 1'b1;
				second_q <= 1'b0;
			end else if (!q_status.empty) begin
				valid_q  <= 1'b1;
				second_q <= head_job.two;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			if (second_q) begin
				job_q  <= CLEAR_JOB;
				last_q <= 1'b1;
			end else if (!q_status.empty) begin
				job_q  <= head_job;
				last_q <= !head_job.two;
			end
		end
	end

endmodule

[sv/touch_report_frame_decoder_top.sv]
// touch_report_frame_decoder_top: touch controller coordinate report decoder
// instantiates trfd_front, trfd_queue and trfd_back; depends on trfd_pkg
//
// Usage:
//   Input channel (in_valid/in_stall) takes one report word per unstalled
//   cycle: frame_start marks the status byte, data_byte is the raw byte.
//   Result channel (out_valid/out_stall) gives events: event_kind, point_id,
//   x_coord, y_coord, touch_size and last, set on the final event of a byte.
//   Configuration: cfg_write with cfg_index 0 writes touch_disable, index 1
//   writes raw_mode, both from cfg_data bit 0; write only while idle.
// Timing:
//   The front classifies one byte per unstalled cycle and pushes a job into
//   a four-entry queue; the back drains one event per unstalled cycle into
//   an output register. A byte's clear-status event, if it has one, follows
//   its first event ahead of the next job. in_stall rises when the queue
//   is full, which happens only while the receiver holds out_stall; the
//   held event stays stable until taken.
// Reset: arst_n clears frame state, previous count, queue and output valid.
`timescale 1ns / 1ps

module touch_report_frame_decoder_top #(
	parameter int MAX_POINTS = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        frame_start,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  event_kind,
	output logic [3:0]  point_id,
	output logic [15:0] x_coord,
	output logic [15:0] y_coord,
	output logic [15:0] touch_size,
	output logic        last
);
	import trfd_pkg::*;

	localparam logic REG_TOUCH_DISABLE = 1'b0;
	localparam logic REG_RAW_MODE      = 1'b1;

	logic      touch_disable_q;
	logic      raw_mode_q;
	logic      accept;
	logic      push;
	job_t      push_job;
	logic      pop;
	job_t      head_job;
	q_status_t q_status;
	job_t      out_job;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touch_disable_q <= 1'b0;
			raw_mode_q      <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_TOUCH_DISABLE: touch_disable_q <= cfg_data;
				REG_RAW_MODE:      raw_mode_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall = q_status.full;
	assign accept   = in_valid && !in_stall;

	trfd_front #(
		.MAX_POINTS(MAX_POINTS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.touch_disable(touch_disable_q),
		.raw_mode     (raw_mode_q),
		.accept       (accept),
		.frame_start  (frame_start),
		.data_byte    (data_byte),
		.push         (push),
		.push_job     (push_job)
	);

	trfd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.head_job(head_job),
		.status  (q_status)
	);

	trfd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_job (head_job),
		.q_status (q_status),
		.pop      (pop),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_job  (out_job),
		.out_last (last)
	);

	// result payload
	assign event_kind = out_job.kind;
	assign point_id   = out_job.id;
	assign x_coord    = out_job.x;
	assign y_coord    = out_job.y;
	assign touch_size = out_job.w;

endmodule
